### design/lcdseq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the character lcd nibble port sequencer
package lcdseq_pkg;

  typedef enum logic [1:0] {
    OP_SEND      = 2'd0,
    OP_CLEAR     = 2'd1,
    OP_BACKLIGHT = 2'd2,
    OP_INIT      = 2'd3
  } opcode_t;

  // what a datapath command does to the port image
  typedef enum logic [2:0] {
    K_RS,
    K_EN,
    K_BL,
    K_DATA,
    K_PREP
  } wr_kind_t;

  // configuration register indexes
  localparam logic [2:0] REG_RS        = 3'd0;
  localparam logic [2:0] REG_ENABLE    = 3'd1;
  localparam logic [2:0] REG_BACKLIGHT = 3'd2;
  localparam logic [2:0] REG_D4        = 3'd3;
  localparam logic [2:0] REG_D5        = 3'd4;
  localparam logic [2:0] REG_D6        = 3'd5;
  localparam logic [2:0] REG_D7        = 3'd6;

  // reset positions
  localparam logic [2:0] RST_RS_POS        = 3'd0;
  localparam logic [2:0] RST_ENABLE_POS    = 3'd2;
  localparam logic [2:0] RST_BACKLIGHT_POS = 3'd3;
  localparam logic [2:0] RST_D4_POS        = 3'd4;
  localparam logic [2:0] RST_D5_POS        = 3'd5;
  localparam logic [2:0] RST_D6_POS        = 3'd6;
  localparam logic [2:0] RST_D7_POS        = 3'd7;

  // lcd commands and wake nibbles
  localparam logic [7:0] LCD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0c;
  localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] LCD_CLEAR        = 8'h01;
  localparam logic [3:0] NIB_WAKE         = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;
  localparam logic [3:0] NIB_MASK         = 4'hf;

  // delays in microseconds
  localparam logic [13:0] DLY_POWER_UP = 14'd15000;
  localparam logic [12:0] DLY_RS_SETUP = 13'd100;
  localparam logic [12:0] DLY_NIBBLE   = 13'd1000;
  localparam logic [12:0] DLY_CMD      = 13'd40;
  localparam logic [12:0] DLY_CLEAR    = 13'd2040;
  localparam logic [12:0] DLY_WAKE     = 13'd5000;
  localparam logic [12:0] DLY_FOUR_BIT = 13'd1000;

  // controller to datapath
  typedef struct packed {
    logic        update;  // apply kind to port image
    logic        emit;    // load a word into the output register
    wr_kind_t    kind;
    logic        level;
    logic [3:0]  nibble;
    logic [13:0] before_us;
    logic [12:0] after_us;
    logic        last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
  } dp_sts_t;

  function automatic logic [7:0] drive_bit(logic [7:0] img, logic [2:0] pos, logic level);
    logic [7:0] r;
    r      = img;
    r[pos] = level;
    return r;
  endfunction

endpackage

### design/lcdseq_cmd_if.sv
`timescale 1ns / 1ps
// command channel interface
interface lcdseq_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       rs_select;
  logic [7:0] value_byte;
  logic       backlight_on;

  modport source (output valid, output opcode, output rs_select, output value_byte,
                  output backlight_on, input ready);
  modport sink (input valid, input opcode, input rs_select, input value_byte,
                input backlight_on, output ready);
endinterface

### design/lcdseq_wr_if.sv
`timescale 1ns / 1ps
// port write channel interface
interface lcdseq_wr_if;
  logic        valid;
  logic        ready;
  logic [7:0]  port_byte;
  logic [13:0] delay_before_us;
  logic [12:0] delay_after_us;
  logic        last;

  modport source (output valid, output port_byte, output delay_before_us,
                  output delay_after_us, output last, input ready);
  modport sink (input valid, input port_byte, input delay_before_us,
                input delay_after_us, input last, output ready);
endinterface

### design/lcdseq_ctrl.sv
`timescale 1ns / 1ps
// sequencing controller: walks the write steps of each command
module lcdseq_ctrl (
  input  logic                clk,
  input  logic                rst,
  lcdseq_cmd_if.sink          cmd,
  input  lcdseq_pkg::dp_sts_t sts,
  output lcdseq_pkg::dp_cmd_t dpc
);
  import lcdseq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_PREP, S_RUN} state_t;

  state_t     state;
  opcode_t    op;
  logic       rs_sel;
  logic [7:0] val;
  logic       light;
  logic [2:0] seg;   // init segment: 0..2 wake nibbles, 3 four-bit nibble, 4..7 commands
  logic [2:0] step;

  logic [7:0] cur_byte;
  logic       nibble_seg;
  logic       is_clear;
  logic       final_seg;
  logic       seg_end;
  dp_cmd_t    w;

  always_comb begin
    unique case (seg[1:0])
      2'd0:    cur_byte = LCD_FUNCTION_SET;
      2'd1:    cur_byte = LCD_DISPLAY_ON;
      2'd2:    cur_byte = LCD_CLEAR;
      default: cur_byte = LCD_ENTRY_MODE;
    endcase
    if (op == OP_CLEAR) cur_byte = LCD_CLEAR;
    else if (op == OP_SEND) cur_byte = val;
  end

  assign nibble_seg = (op == OP_INIT) && !seg[2];
  assign is_clear   = (op == OP_CLEAR) || ((op == OP_INIT) && (seg == 3'd6));
  assign final_seg  = (op != OP_INIT) || (seg == 3'd7);

  always_comb begin
    w           = '0;
    w.kind      = K_EN;
    w.nibble    = '0;
    seg_end     = 1'b0;
    if (op == OP_BACKLIGHT) begin
      w.kind  = K_BL;
      w.level = light;
      w.last  = 1'b1;
      seg_end = 1'b1;
    end else if (nibble_seg) begin
      w.nibble = (seg == 3'd3) ? NIB_FOUR_BIT : NIB_WAKE;
      unique case (step)
        3'd0: begin
          w.kind      = K_DATA;
          w.before_us = (seg == 3'd0) ? DLY_POWER_UP : 14'd0;
          w.after_us  = DLY_NIBBLE;
        end
        3'd1: begin
          w.level = 1'b1;
        end
        default: begin
          w.after_us = (seg == 3'd3) ? DLY_FOUR_BIT : DLY_WAKE;
          seg_end    = 1'b1;
        end
      endcase
    end else begin
      unique case (step)
        3'd0: begin
          w.kind     = K_RS;
          w.level    = (op == OP_SEND) ? rs_sel : 1'b0;
          w.after_us = DLY_RS_SETUP;
        end
        3'd1: ;
        3'd2: begin
          w.kind     = K_DATA;
          w.nibble   = cur_byte[7:4];
          w.after_us = DLY_NIBBLE;
        end
        3'd3: w.level = 1'b1;
        3'd4: ;
        3'd5: begin
          w.kind     = K_DATA;
          w.nibble   = cur_byte[3:0] & NIB_MASK;
          w.after_us = DLY_NIBBLE;
        end
        3'd6: w.level = 1'b1;
        default: begin
          w.after_us = is_clear ? DLY_CLEAR : DLY_CMD;
          w.last     = final_seg;
          seg_end    = 1'b1;
        end
      endcase
    end
    if (state == S_PREP) begin
      w.kind = K_PREP;
    end
    w.emit   = (state == S_RUN) && sts.slot_free;
    w.update = w.emit || (state == S_PREP);
    dpc      = w;
  end

  assign cmd.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_SEND;
      seg   <= '0;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op     <= opcode_t'(cmd.opcode);
            rs_sel <= cmd.rs_select;
            val    <= cmd.value_byte;
            light  <= cmd.backlight_on;
            seg    <= '0;
            step   <= '0;
            state  <= (opcode_t'(cmd.opcode) == OP_INIT) ? S_PREP : S_RUN;
          end
        end
        S_PREP: state <= S_RUN;
        default: begin
          if (w.emit) begin
            if (w.last) begin
              state <= S_IDLE;
            end else if (seg_end) begin
              seg  <= seg + 3'd1;
              step <= '0;
            end else begin
              step <= step + 3'd1;
            end
          end
        end
      endcase
    end
  end

endmodule

### design/lcdseq_dp.sv
`timescale 1ns / 1ps
// datapath: line positions, port image and output register
module lcdseq_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [2:0]          cfg_data,
  input  lcdseq_pkg::dp_cmd_t dpc,
  output lcdseq_pkg::dp_sts_t sts,
  lcdseq_wr_if.source         wr
);
  import lcdseq_pkg::*;

  logic [2:0]  rs_pos;
  logic [2:0]  en_pos;
  logic [2:0]  bl_pos;
  logic [2:0]  d4_pos;
  logic [2:0]  d5_pos;
  logic [2:0]  d6_pos;
  logic [2:0]  d7_pos;
  logic [7:0]  port_image;
  logic [7:0]  port_image_next;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic [13:0] out_before;
  logic [12:0] out_after;
  logic        out_last;

  // shared positions: later line wins
  always_comb begin
    port_image_next = port_image;
    unique case (dpc.kind)
      K_RS: port_image_next = drive_bit(port_image, rs_pos, dpc.level);
      K_EN: port_image_next = drive_bit(port_image, en_pos, dpc.level);
      K_BL: port_image_next = drive_bit(port_image, bl_pos, dpc.level);
      K_DATA: begin
        port_image_next = drive_bit(port_image_next, d4_pos, dpc.nibble[0]);
        port_image_next = drive_bit(port_image_next, d5_pos, dpc.nibble[1]);
        port_image_next = drive_bit(port_image_next, d6_pos, dpc.nibble[2]);
        port_image_next = drive_bit(port_image_next, d7_pos, dpc.nibble[3]);
      end
      default: begin
        port_image_next = drive_bit(port_image_next, d4_pos, 1'b0);
        port_image_next = drive_bit(port_image_next, d5_pos, 1'b0);
        port_image_next = drive_bit(port_image_next, d6_pos, 1'b0);
        port_image_next = drive_bit(port_image_next, d7_pos, 1'b0);
        port_image_next = drive_bit(port_image_next, en_pos, 1'b0);
      end
    endcase
  end

  assign sts.slot_free = !out_valid || wr.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rs_pos     <= RST_RS_POS;
      en_pos     <= RST_ENABLE_POS;
      bl_pos     <= RST_BACKLIGHT_POS;
      d4_pos     <= RST_D4_POS;
      d5_pos     <= RST_D5_POS;
      d6_pos     <= RST_D6_POS;
      d7_pos     <= RST_D7_POS;
      port_image <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_RS:        rs_pos <= cfg_data;
          REG_ENABLE:    en_pos <= cfg_data;
          REG_BACKLIGHT: bl_pos <= cfg_data;
          REG_D4:        d4_pos <= cfg_data;
          REG_D5:        d5_pos <= cfg_data;
          REG_D6:        d6_pos <= cfg_data;
          REG_D7:        d7_pos <= cfg_data;
          default: ;
        endcase
      end
      if (dpc.update) begin
        port_image <= port_image_next;
      end
      if (dpc.emit) begin
        out_valid <= 1'b1;
      end else if (wr.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dpc.emit) begin
      out_byte   <= port_image_next;
      out_before <= dpc.before_us;
      out_after  <= dpc.after_us;
      out_last   <= dpc.last;
    end
  end

  assign wr.valid           = out_valid;
  assign wr.port_byte       = out_byte;
  assign wr.delay_before_us = out_before;
  assign wr.delay_after_us  = out_after;
  assign wr.last            = out_last;

endmodule

### design/char_lcd_nibble_port_sequencer.sv
`timescale 1ns / 1ps
// top level of the character lcd nibble port sequencer
//
// drives a character lcd in 4-bit mode through an 8-bit port expander
// - cmd channel: one word per command (send byte, clear, backlight, init)
// - wr channel: one word per expander write, the port byte plus the waits
//   to keep before and after it; last marks the final write of a command
// - cfg port: cfg_write/cfg_index/cfg_data place rs, e, backlight and
//   d4..d7 on port bits; write only while the block is idle
// throughput: one write word per cycle while the receiver takes them; once
//   a command is accepted, send byte and clear issue 8 writes, backlight 1
//   and init 44, init first pre-clearing the data and enable lines; the
//   step sequencer in the controller sets the order of these writes
// first word: the controller registers the command, and for init enters
//   the pre-clear state, before the first write goes to the output register
// a new command is taken as soon as its predecessor's last write is loaded
//   into the output register, even while that word still waits
// when the receiver stalls, the output register holds its word and the
//   sequencer waits on it; nothing is dropped
// reset: positions go to their defaults, the port image clears, no word out
module char_lcd_nibble_port_sequencer (
  input  logic        clk,
  input  logic        rst,
  lcdseq_cmd_if.sink  cmd,
  lcdseq_wr_if.source wr,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [2:0]  cfg_data
);
  import lcdseq_pkg::*;

  dp_cmd_t dpc;  // step command from the sequencer
  dp_sts_t sts;  // output slot status back to the sequencer

  // command decode and step sequencing
  lcdseq_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .dpc (dpc)
  );

  // line placement, port image and output word register
  lcdseq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dpc       (dpc),
    .sts       (sts),
    .wr        (wr)
  );

endmodule

### design/lcdseq_checker.sv
`timescale 1ns / 1ps
// port checker of the sequencer and its bind
module lcdseq_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        wr_valid,
  input logic        wr_ready,
  input logic [7:0]  wr_port_byte,
  input logic [13:0] wr_before,
  input logic [12:0] wr_after,
  input logic        wr_last
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (wr_valid && !wr_ready) |=> (wr_valid && $stable(wr_port_byte) && $stable(wr_last)))
    else $error("stalled write word changed");

  // no word straight out of reset
  a_reset: assert property (@(posedge clk) rst |=> !wr_valid)
    else $error("write word valid after reset");

  // one command at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("command taken while busy");

  // only the power-up wait comes before a write
  a_before: assert property (@(posedge clk) disable iff (rst)
    (wr_valid && wr_before != 14'd0) |-> (wr_before == 14'd15000))
    else $error("unexpected delay before write");

  // a command ends with one of the known settle times
  a_last: assert property (@(posedge clk) disable iff (rst)
    (wr_valid && wr_last) |->
      (wr_after == 13'd0 || wr_after == 13'd40 || wr_after == 13'd2040))
    else $error("unexpected delay after last write");

endmodule

bind char_lcd_nibble_port_sequencer lcdseq_checker u_lcdseq_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .wr_valid     (wr.valid),
  .wr_ready     (wr.ready),
  .wr_port_byte (wr.port_byte),
  .wr_before    (wr.delay_before_us),
  .wr_after     (wr.delay_after_us),
  .wr_last      (wr.last)
);
